>>> sv/tq_pkg.sv
package tq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 32;

    typedef enum logic [2:0] {
        FN_ADVANCE   = 3'd0,
        FN_SCHED_ABS = 3'd1,
        FN_SCHED_REL = 3'd2,
        FN_CANCEL    = 3'd3,
        FN_RUN_UNTIL = 3'd4,
        FN_STEP      = 3'd5
    } tq_func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_PAST_CYCLE = 3'd1,
        ST_OVERFLOW   = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_TARGET     = 3'd4,
        ST_LIMIT      = 3'd5,
        ST_QUEUE_FULL = 3'd6
    } tq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } tq_state_t;

    localparam logic KIND_NOTICE     = 1'b0;
    localparam logic KIND_COMPLETION = 1'b1;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;     // take the new entry
        logic free_go;  // free the entry whose rank equals free_rank
    } tq_cell_ctl_t;

endpackage

>>> sv/tq_cell.sv
module tq_cell #(
    parameter int ID_WIDTH = 32,
    parameter int RANK_W   = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tq_pkg::tq_cell_ctl_t ctl,
    input  logic [63:0]          ld_cycle,
    input  logic [ID_WIDTH-1:0]  ld_id,
    input  logic [RANK_W-1:0]    ld_rank,
    input  logic [RANK_W-1:0]    free_rank,
    input  logic [ID_WIDTH-1:0]  match_id,
    output logic                 slot_valid,
    output logic [RANK_W-1:0]    slot_rank,
    output logic                 match,
    input  logic                 in_hit,
    input  logic [63:0]          in_cyc,
    input  logic [RANK_W-1:0]    in_rank,
    input  logic [ID_WIDTH-1:0]  in_id,
    output logic                 out_hit,
    output logic [63:0]          out_cyc,
    output logic [RANK_W-1:0]    out_rank,
    output logic [ID_WIDTH-1:0]  out_id
);
    import tq_pkg::*;

    logic                valid_reg;
    logic [63:0]         cycle_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic                hit_reg;
    logic [63:0]         cyc_o_reg;
    logic [RANK_W-1:0]   rank_o_reg;
    logic [ID_WIDTH-1:0] id_o_reg;
    logic                better;

    // own entry beats the candidate: earlier cycle, then older rank
    assign better = valid_reg && (!in_hit || (cycle_reg < in_cyc) ||
                    ((cycle_reg == in_cyc) && (rank_reg < in_rank)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            if (ctl.load) begin
                valid_reg <= 1'b1;
            end else if (ctl.free_go && valid_reg && (rank_reg == free_rank)) begin
                valid_reg <= 1'b0;
            end
            hit_reg <= better || in_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cycle_reg <= ld_cycle;
            id_reg    <= ld_id;
            rank_reg  <= ld_rank;
        end else if (ctl.free_go && valid_reg && (rank_reg > free_rank)) begin
            rank_reg <= rank_reg - 1'b1;
        end
        if (better) begin
            cyc_o_reg  <= cycle_reg;
            rank_o_reg <= rank_reg;
            id_o_reg   <= id_reg;
        end else begin
            cyc_o_reg  <= in_cyc;
            rank_o_reg <= in_rank;
            id_o_reg   <= in_id;
        end
    end

    assign slot_valid = valid_reg;
    assign slot_rank  = rank_reg;
    assign match      = valid_reg && (id_reg == match_id);
    assign out_hit    = hit_reg;
    assign out_cyc    = cyc_o_reg;
    assign out_rank   = rank_o_reg;
    assign out_id     = id_o_reg;

endmodule

>>> sv/timed_event_queue.sv
// Channel  | Ports                                       | Direction
// command  | s_valid s_ready s_func s_cycle_value        | in
//          | s_event_id s_max_events                     |
// result   | m_valid m_ready m_kind m_status m_id_out    | out
//          | m_cycle_out m_last                          |
// config   | cfg_valid cfg_ready cfg_data (start cycle)  | in
//
// Advance, schedule, cancel: the command passes S_EXEC and S_DONE before its completion is registered.
// Run and step: every search for the earliest event walks the full cell chain once.
// One command at a time; s_ready is high only while idle, even when a
// completion still waits on m_ready. Stalls on m_ready hold the run.
// Reset (aresetn low, synchronous) empties the queue, zeroes the clock and ids.
module timed_event_queue #(
    parameter int QUEUE_DEPTH = tq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = tq_pkg::ID_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [63:0] s_cycle_value,
    input  logic [31:0] s_event_id,
    input  logic [5:0]  s_max_events,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [2:0]  m_status,
    output logic [31:0] m_id_out,
    output logic [63:0] m_cycle_out,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);
    import tq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = AW + 1;

    tq_state_t           state_reg, state_next;
    logic [63:0]         clock_reg, clock_next;
    logic [ID_WIDTH-1:0] next_id_reg, next_id_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [2:0]          func_reg;
    logic [63:0]         cv_reg;
    logic [31:0]         eid_reg;
    logic [5:0]          max_reg;
    logic [63:0]         tgt_reg, tgt_next;
    logic [5:0]          fired_reg, fired_next;
    logic [CW-1:0]       wait_reg, wait_next;
    tq_status_t          status_reg, status_next;
    logic [ID_WIDTH-1:0] idres_reg, idres_next;

    logic                mv_reg, mv_next;
    logic                mk_reg, mk_next;
    logic [2:0]          ms_reg, ms_next;
    logic [31:0]         mid_reg, mid_next;
    logic [63:0]         mc_reg, mc_next;
    logic                ml_reg, ml_next;

    // cell chain
    tq_cell_ctl_t        ctl    [QUEUE_DEPTH];
    logic                vld    [QUEUE_DEPTH];
    logic [AW-1:0]       rnk    [QUEUE_DEPTH];
    logic                mtch   [QUEUE_DEPTH];
    logic                c_hit  [QUEUE_DEPTH+1];
    logic [63:0]         c_cyc  [QUEUE_DEPTH+1];
    logic [AW-1:0]       c_rank [QUEUE_DEPTH+1];
    logic [ID_WIDTH-1:0] c_id   [QUEUE_DEPTH+1];

    logic                load_go, free_go;
    logic [AW-1:0]       free_rank;
    logic [QUEUE_DEPTH-1:0] free_oh;
    logic                any_match;
    logic [AW-1:0]       match_rank;
    logic [ID_WIDTH-1:0] eid_fit;
    logic                eid_hi_ok;
    logic [ID_WIDTH+31:0] eid_wide, idw_out;
    logic [64:0]         sum65;
    logic                out_free;

    // chain head carries no candidate
    assign c_hit[0]  = 1'b0;
    assign c_cyc[0]  = '0;
    assign c_rank[0] = '0;
    assign c_id[0]   = '0;

    // event id into slot id width; out-of-range bits never match
    assign eid_wide  = {{ID_WIDTH{1'b0}}, eid_reg};
    assign eid_fit   = eid_wide[ID_WIDTH-1:0];
    assign eid_hi_ok = (eid_wide[ID_WIDTH+31:ID_WIDTH] == 32'd0);

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        tq_cell #(.ID_WIDTH(ID_WIDTH), .RANK_W(AW)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl[g]),
            .ld_cycle   (tgt_next),
            .ld_id      (next_id_reg),
            .ld_rank    (cnt_reg[AW-1:0]),
            .free_rank  (free_rank),
            .match_id   (eid_fit),
            .slot_valid (vld[g]),
            .slot_rank  (rnk[g]),
            .match      (mtch[g]),
            .in_hit     (c_hit[g]),
            .in_cyc     (c_cyc[g]),
            .in_rank    (c_rank[g]),
            .in_id      (c_id[g]),
            .out_hit    (c_hit[g+1]),
            .out_cyc    (c_cyc[g+1]),
            .out_rank   (c_rank[g+1]),
            .out_id     (c_id[g+1])
        );
        assign ctl[g] = '{load: load_go && free_oh[g], free_go: free_go};
    end

    // lowest free slot, lowest matching slot
    always_comb begin
        logic seen_free, seen_match;
        seen_free  = 1'b0;
        seen_match = 1'b0;
        free_oh    = '0;
        match_rank = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (!vld[i] && !seen_free) begin
                free_oh[i] = 1'b1;
                seen_free  = 1'b1;
            end
            if (mtch[i] && eid_hi_ok && !seen_match) begin
                match_rank = rnk[i];
                seen_match = 1'b1;
            end
        end
        any_match = seen_match;
    end

    assign sum65    = {1'b0, clock_reg} + {1'b0, cv_reg};
    assign out_free = !mv_reg || m_ready;
    assign idw_out  = {32'd0, idres_reg};

    always_comb begin
        state_next   = state_reg;
        clock_next   = clock_reg;
        next_id_next = next_id_reg;
        cnt_next     = cnt_reg;
        tgt_next     = tgt_reg;
        fired_next   = fired_reg;
        wait_next    = wait_reg;
        status_next  = status_reg;
        idres_next   = idres_reg;
        load_go      = 1'b0;
        free_go      = 1'b0;
        free_rank    = match_rank;
        mv_next      = mv_reg && !m_ready;
        mk_next      = mk_reg;
        ms_next      = ms_reg;
        mid_next     = mid_reg;
        mc_next      = mc_reg;
        ml_next      = ml_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    idres_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                unique case (func_reg)
                    FN_ADVANCE: begin
                        if (sum65[64]) status_next = ST_OVERFLOW;
                        else clock_next = sum65[63:0];
                    end
                    FN_SCHED_ABS, FN_SCHED_REL: begin
                        tgt_next = (func_reg == FN_SCHED_ABS) ? cv_reg : sum65[63:0];
                        if (func_reg == FN_SCHED_REL && sum65[64]) begin
                            status_next = ST_OVERFLOW;
                        end else if (func_reg == FN_SCHED_ABS && cv_reg < clock_reg) begin
                            status_next = ST_PAST_CYCLE;
                        end else if (cnt_reg == CW'(QUEUE_DEPTH)) begin
                            status_next = ST_QUEUE_FULL;
                        end else begin
                            load_go      = 1'b1;
                            cnt_next     = cnt_reg + 1'b1;
                            idres_next   = next_id_reg;
                            next_id_next = next_id_reg + 1'b1;
                        end
                    end
                    FN_CANCEL: begin
                        if (any_match) begin
                            free_go  = 1'b1;
                            cnt_next = cnt_reg - 1'b1;
                        end else begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    FN_RUN_UNTIL, FN_STEP: begin
                        tgt_next   = (func_reg == FN_RUN_UNTIL) ? cv_reg : sum65[63:0];
                        fired_next = '0;
                        wait_next  = CW'(QUEUE_DEPTH);
                        if (func_reg == FN_STEP && sum65[64]) begin
                            status_next = ST_OVERFLOW;
                        end else if (func_reg == FN_RUN_UNTIL && cv_reg < clock_reg) begin
                            status_next = ST_PAST_CYCLE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                // chain tail is settled once wait reaches zero
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else if (!c_hit[QUEUE_DEPTH] || c_cyc[QUEUE_DEPTH] > tgt_reg) begin
                    clock_next  = tgt_reg;
                    status_next = ST_TARGET;
                    state_next  = S_DONE;
                end else if (fired_reg >= max_reg) begin
                    status_next = ST_LIMIT;
                    state_next  = S_DONE;
                end else if (out_free) begin
                    mv_next    = 1'b1;
                    mk_next    = KIND_NOTICE;
                    ms_next    = ST_OK;
                    mid_next   = 32'({32'd0, c_id[QUEUE_DEPTH]});
                    mc_next    = c_cyc[QUEUE_DEPTH];
                    ml_next    = 1'b0;
                    free_go    = 1'b1;
                    free_rank  = c_rank[QUEUE_DEPTH];
                    cnt_next   = cnt_reg - 1'b1;
                    clock_next = c_cyc[QUEUE_DEPTH];
                    fired_next = fired_reg + 1'b1;
                    wait_next  = CW'(QUEUE_DEPTH);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mk_next    = KIND_COMPLETION;
                    ms_next    = status_reg;
                    mid_next   = idw_out[31:0];
                    mc_next    = clock_reg;
                    ml_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // register write must land only while idle; the block itself does not enforce it
        if (cfg_valid) clock_next = cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            clock_reg   <= '0;
            next_id_reg <= '0;
            cnt_reg     <= '0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            next_id_reg <= next_id_next;
            cnt_reg     <= cnt_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            func_reg <= s_func;
            cv_reg   <= s_cycle_value;
            eid_reg  <= s_event_id;
            max_reg  <= s_max_events;
        end
        tgt_reg    <= tgt_next;
        fired_reg  <= fired_next;
        wait_reg   <= wait_next;
        status_reg <= status_next;
        idres_reg  <= idres_next;
        mk_reg     <= mk_next;
        ms_reg     <= ms_next;
        mid_reg    <= mid_next;
        mc_reg     <= mc_next;
        ml_reg     <= ml_next;
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = mv_reg;
    assign m_kind      = mk_reg;
    assign m_status    = ms_reg;
    assign m_id_out    = mid_reg;
    assign m_cycle_out = mc_reg;
    assign m_last      = ml_reg;

endmodule

>>> verif/timed_event_queue_tb.sv
`default_nettype none

module timed_event_queue_tb;
    import tq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    // One result transfer as the block should present it.
    typedef struct {
        logic        kind;
        tq_status_t  status;
        logic [31:0] id_out;
        logic [63:0] cycle_out;
        logic        last;
    } tq_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [63:0] s_cycle_value = '0;
    logic [31:0] s_event_id = '0;
    logic [5:0]  s_max_events = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [2:0]  m_status;
    logic [31:0] m_id_out;
    logic [63:0] m_cycle_out;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_data = '0;

    timed_event_queue i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_cycle_value(s_cycle_value),
        .s_event_id   (s_event_id),
        .s_max_events (s_max_events),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_status     (m_status),
        .m_id_out     (m_id_out),
        .m_cycle_out  (m_cycle_out),
        .m_last       (m_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow of the event queue: clock, id counter, slots and tie-break ages
    // ------------------------------------------------------------------
    logic [63:0]     sim_clock;
    logic [31:0]     sim_next_id;
    bit              slot_live [DEPTH];
    logic [63:0]     slot_when [DEPTH];
    logic [31:0]     slot_tag  [DEPTH];
    longint unsigned slot_seq  [DEPTH];
    longint unsigned seq_ctr;

    tq_result_t pending_results[$];
    int         error_count = 0;

    // Traffic shaping, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;   // receiver hold-off, counted down below

    function automatic void push_result(logic kind, tq_status_t st, logic [31:0] id,
                                        logic [63:0] cyc, logic last);
        tq_result_t r;
        r.kind = kind;
        r.status = st;
        r.id_out = id;
        r.cycle_out = cyc;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function automatic void clear_queue_state(logic [63:0] start);
        sim_clock = start;
        sim_next_id = '0;
        seq_ctr = 0;
        foreach (slot_live[i]) slot_live[i] = 1'b0;
    endfunction

    // Insert into the lowest free slot; past check comes before full check.
    function automatic tq_status_t insert_event(logic [63:0] tgt, output logic [31:0] id);
        id = '0;
        if (tgt < sim_clock) return ST_PAST_CYCLE;
        for (int i = 0; i < DEPTH; i++) begin
            if (!slot_live[i]) begin
                slot_live[i] = 1'b1;
                slot_when[i] = tgt;
                slot_tag[i] = sim_next_id;
                slot_seq[i] = seq_ctr;
                seq_ctr++;
                id = sim_next_id;
                sim_next_id = sim_next_id + 32'd1;
                return ST_OK;
            end
        end
        return ST_QUEUE_FULL;
    endfunction

    // Fire due events earliest first (older wins a tie), one notice each.
    function automatic tq_status_t fire_due(logic [63:0] tgt, logic [5:0] limit);
        int fired;
        int best;
        fired = 0;
        if (tgt < sim_clock) return ST_PAST_CYCLE;
        forever begin
            best = -1;
            for (int i = 0; i < DEPTH; i++) begin
                if (slot_live[i] && (best < 0 || slot_when[i] < slot_when[best] ||
                    (slot_when[i] == slot_when[best] && slot_seq[i] < slot_seq[best])))
                    best = i;
            end
            if (best < 0 || slot_when[best] > tgt) break;
            if (fired >= limit) return ST_LIMIT;
            slot_live[best] = 1'b0;
            sim_clock = slot_when[best];
            push_result(KIND_NOTICE, ST_OK, slot_tag[best], sim_clock, 1'b0);
            fired++;
        end
        sim_clock = tgt;
        return ST_TARGET;
    endfunction

    function automatic void predict_command(tq_func_t fn, logic [63:0] cv,
                                            logic [31:0] eid, logic [5:0] limit);
        logic [63:0] sum;
        logic        ovf;
        tq_status_t  st;
        logic [31:0] id;
        sum = sim_clock + cv;
        ovf = sum < sim_clock;
        st = ST_OK;
        id = '0;
        case (fn)
            FN_ADVANCE: begin
                if (ovf) st = ST_OVERFLOW;
                else sim_clock = sum;
            end
            FN_SCHED_ABS: st = insert_event(cv, id);
            FN_SCHED_REL: begin
                if (ovf) st = ST_OVERFLOW;
                else st = insert_event(sum, id);
            end
            FN_CANCEL: begin
                st = ST_NOT_FOUND;
                for (int i = 0; i < DEPTH; i++) begin
                    if (slot_live[i] && slot_tag[i] == eid) begin
                        slot_live[i] = 1'b0;
                        st = ST_OK;
                        break;
                    end
                end
            end
            FN_RUN_UNTIL: st = fire_due(cv, limit);
            FN_STEP: begin
                if (ovf) st = ST_OVERFLOW;
                else st = fire_due(sum, limit);
            end
            default: ;
        endcase
        if (st != ST_OK) id = '0;
        push_result(KIND_COMPLETION, st, id, sim_clock, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Command channel: random idle gap, then hold valid until the transfer
    // ------------------------------------------------------------------
    task automatic send_cmd(tq_func_t fn, logic [63:0] cv, logic [31:0] eid,
                            logic [5:0] limit);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_cycle_value <= cv;
        s_event_id <= eid;
        s_max_events <= limit;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_command(fn, cv, eid, limit);
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
    endtask

    // Wait until every expected result has been seen.
    task automatic wait_drained();
        end_burst();
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Start-cycle write; only issued with the block idle.
    task automatic write_start_cycle(logic [63:0] value);
        wait_drained();
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sim_clock = value;  // queue contents stay as they are
    endtask

    // ------------------------------------------------------------------
    // Result channel: random stalls plus the long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        tq_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer kind=%0d status=%0d id=%0h cyc=%0h",
                         $time, m_kind, m_status, m_id_out, m_cycle_out);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_kind !== exp_r.kind) begin
                    $display("%0t: kind exp %0d act %0d", $time, exp_r.kind, m_kind);
                    error_count++;
                end
                if (m_status !== exp_r.status) begin
                    $display("%0t: status exp %0d act %0d", $time, exp_r.status, m_status);
                    error_count++;
                end
                if (m_id_out !== exp_r.id_out) begin
                    $display("%0t: id_out exp %0h act %0h", $time, exp_r.id_out, m_id_out);
                    error_count++;
                end
                if (m_cycle_out !== exp_r.cycle_out) begin
                    $display("%0t: cycle_out exp %0h act %0h", $time, exp_r.cycle_out,
                             m_cycle_out);
                    error_count++;
                end
                if (m_last !== exp_r.last) begin
                    $display("%0t: last exp %0d act %0d", $time, exp_r.last, m_last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    // Hand-picked corners: ties, cancels, past targets, full store, limits,
    // overflow on every arithmetic path.
    task automatic test_directed();
        write_start_cycle(64'd0);
        send_cmd(FN_ADVANCE, 64'd0, 32'd0, 6'd0);
        send_cmd(FN_SCHED_ABS, 64'd100, 32'd0, 6'd0);
        send_cmd(FN_SCHED_ABS, 64'd100, 32'd0, 6'd0);      // tie, younger
        send_cmd(FN_SCHED_REL, 64'd50, 32'd0, 6'd0);
        send_cmd(FN_SCHED_ABS, 64'd0, 32'd0, 6'd0);        // due right now
        send_cmd(FN_CANCEL, 64'd0, 32'd1, 6'd0);
        send_cmd(FN_CANCEL, 64'd0, 32'hFFFF_FFFF, 6'd0);   // unknown id
        send_cmd(FN_RUN_UNTIL, 64'd200, 32'd0, 6'd63);
        send_cmd(FN_SCHED_ABS, 64'd10, 32'd0, 6'd0);       // in the past
        send_cmd(FN_RUN_UNTIL, 64'd5, 32'd0, 6'd63);       // target in the past
        for (int i = 0; i < DEPTH + 1; i++)               // last one finds it full
            send_cmd(FN_SCHED_REL, 64'(i % 5), 32'd0, 6'd0);
        send_cmd(FN_STEP, 64'd100, 32'd0, 6'd3);           // stops at the limit
        send_cmd(FN_STEP, 64'd100, 32'd0, 6'd0);           // limit with no firing
        send_cmd(FN_STEP, 64'd10, 32'd0, 6'd63);
        send_cmd(FN_SCHED_REL, MAX64, 32'd0, 6'd0);
        send_cmd(FN_STEP, MAX64, 32'd0, 6'd63);
        send_cmd(FN_ADVANCE, MAX64, 32'd0, 6'd0);
        // top of the clock range
        write_start_cycle(MAX64 - 64'd2);
        send_cmd(FN_SCHED_ABS, MAX64, 32'd0, 6'd0);
        send_cmd(FN_SCHED_REL, 64'd2, 32'd0, 6'd0);
        send_cmd(FN_SCHED_REL, 64'd3, 32'd0, 6'd0);
        send_cmd(FN_RUN_UNTIL, MAX64, 32'd0, 6'd63);
        send_cmd(FN_ADVANCE, 64'd1, 32'd0, 6'd0);
        send_cmd(FN_STEP, 64'd0, 32'd0, 6'd0);
        wait_drained();
    endtask

    // Random item biased toward live ids and targets near the current clock.
    task automatic send_random_cmd();
        int          pick;
        int          live_idx [$];
        logic [63:0] cv;
        logic [31:0] eid;
        logic [5:0]  limit;
        tq_func_t    fn;
        pick = $urandom_range(99);
        cv = 64'($urandom_range(300));
        eid = $urandom();
        limit = ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(4));
        if ($urandom_range(3) == 0) limit = 6'd63;
        if (pick < 30) fn = FN_SCHED_REL;
        else if (pick < 40) begin
            fn = FN_SCHED_ABS;
            cv = sim_clock + 64'($urandom_range(300)) - 64'd40;
        end else if (pick < 55) begin
            fn = FN_CANCEL;
            foreach (slot_live[i]) if (slot_live[i]) live_idx.push_back(i);
            if (live_idx.size() != 0 && $urandom_range(3) != 0)
                eid = slot_tag[live_idx[$urandom_range(live_idx.size() - 1)]];
            else if ($urandom_range(1) == 0)
                eid = sim_next_id - 32'($urandom_range(3));
        end else if (pick < 70) fn = FN_STEP;
        else if (pick < 85) begin
            fn = FN_RUN_UNTIL;
            cv = sim_clock + 64'($urandom_range(400)) - 64'd20;
        end else if (pick < 90) fn = FN_ADVANCE;
        else begin
            // noise: any function, raw cycle value and limit over the whole field range
            fn = tq_func_t'($urandom_range(5));
            cv = {$urandom(), $urandom()};
            limit = 6'($urandom());
        end
        send_cmd(fn, cv, eid, limit);
    endtask

    task automatic test_random_phase(int n, int idle_pct, int stall_pct, logic [63:0] start);
        write_start_cycle(start);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_random_cmd();
        wait_drained();
    endtask

    // Long receiver hold-off while commands keep coming, then a full drain pause.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        repeat (8) send_cmd(FN_SCHED_REL, 64'($urandom_range(20)), 32'd0, 6'd0);
        send_cmd(FN_STEP, 64'd30, 32'd0, 6'd63);
        wait_drained();
        repeat (6) send_random_cmd();
        wait_drained();
    endtask

    initial begin
        int guard;
        clear_queue_state(64'd0);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(45, 0, 0, 64'd0);
        test_random_phase(35, 68, 0, 64'd1000);
        test_random_phase(35, 0, 68, {$urandom(), $urandom()} >> 2);
        test_random_phase(35, 35, 35, MAX64 - 64'd500);
        test_backpressure();
        test_random_phase(25, 35, 35, 64'd7);

        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (50) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("timed_event_queue_tb: PASS");
        end else begin
            if (pending_results.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         pending_results.size());
            $display("timed_event_queue_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("%0t: timeout", $time);
        $display("timed_event_queue_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
